// ----- src/scd_pkg.sv -----
// Shared types and constants of the sector cache directory.
// Used by the interfaces, the controller, the datapath and the top level.
// Depends on nothing.
package scd_pkg;

	// Field widths of the request and response items
	localparam int OPCODE_W = 2;
	localparam int SECTOR_W = 32;
	localparam int WIN_W    = 10;
	localparam int TICK_W   = 48;
	localparam int ACTION_W = 3;
	localparam int SLOT_W   = 6;
	localparam int PERIOD_W = 32;

	// Default geometry and register reset value
	localparam int SLOT_COUNT_DEF     = 64;
	localparam int SECTOR_BYTES_DEF   = 512;
	localparam logic [PERIOD_W-1:0] FLUSH_PERIOD_RST = 32'd6000;

	typedef enum logic [OPCODE_W-1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_FLUSH = 2'd2,
		OP_DUE   = 2'd3
	} opcode_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_DEV_READ  = 3'd0,
		ACT_DEV_WRITE = 3'd1,
		ACT_COPY_OUT  = 3'd2,
		ACT_COPY_IN   = 3'd3,
		ACT_NOTHING   = 3'd4,
		ACT_STATUS    = 3'd5,
		ACT_REJECTED  = 3'd6
	} action_t;

	// Which response the datapath builds on an emit command
	typedef enum logic [2:0] {
		EK_STATUS  = 3'd0,
		EK_NOTHING = 3'd1,
		EK_REJECT  = 3'd2,
		EK_EVICT   = 3'd3,
		EK_DEVREAD = 3'd4,
		EK_COPY    = 3'd5,
		EK_WT      = 3'd6,
		EK_FLUSH   = 3'd7
	} emit_kind_t;

	// Controller to datapath
	typedef struct packed {
		logic       capture;
		logic       scan_clr;
		logic       scan_adv;
		logic       take_hit;
		logic       rd_en;
		logic       rd_victim;
		logic       alloc;
		logic       tag_wr;
		logic       set_flush_time;
		logic       emit;
		emit_kind_t kind;
		logic       last;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		opcode_t op;
		logic    reject;
		logic    fill_zero;
		logic    full;
		logic    s1_match;
		logic    s1_last;
		logic    scan_last;
		logic    can_emit;
	} status_t;

endpackage

// ----- src/scd_if.sv -----
// Request and response channel interfaces of the sector cache directory.
// Depends on scd_pkg for the field widths.
interface scd_req_if;
	logic                          valid;
	logic                          ready;
	logic [scd_pkg::OPCODE_W-1:0]  opcode;
	logic [scd_pkg::SECTOR_W-1:0]  sector_number;
	logic [scd_pkg::WIN_W-1:0]     window_offset;
	logic [scd_pkg::WIN_W-1:0]     window_length;
	logic [scd_pkg::TICK_W-1:0]    now_ticks;

	modport source (output valid, opcode, sector_number, window_offset, window_length,
		now_ticks, input ready);
	modport sink (input valid, opcode, sector_number, window_offset, window_length,
		now_ticks, output ready);
endinterface

interface scd_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [scd_pkg::ACTION_W-1:0]  action;
	logic [scd_pkg::SECTOR_W-1:0]  device_sector;
	logic [scd_pkg::SLOT_W-1:0]    slot_index;
	logic                          was_hit;
	logic [scd_pkg::WIN_W-1:0]     copy_offset;
	logic [scd_pkg::WIN_W-1:0]     copy_length;
	logic                          flush_due;
	logic                          last_result;

	modport source (output valid, action, device_sector, slot_index, was_hit, copy_offset,
		copy_length, flush_due, last_result, input ready);
	modport sink (input valid, action, device_sector, slot_index, was_hit, copy_offset,
		copy_length, flush_due, last_result, output ready);
endinterface

// ----- src/sector_cache_directory.sv -----
// Top level of the sector cache directory: controller plus datapath.
// Depends on scd_pkg, scd_if, scd_ctrl and scd_dp.
//
//  channel  | dir | handshake       | carries
//  ---------+-----+-----------------+--------------------------------------------
//  req      | in  | valid / ready   | opcode, sector, window, current ticks
//  rsp      | out | valid / ready   | action, device sector, slot, hit, window,
//           |     |                 | flush due, last result flag
//  cfg      | in  | cfg_we          | flush period in ticks
//
// One request at a time; req.ready is high only while the controller is idle.
// Due check and rejected access: decode, then a single response. Access: decode,
// a walk over the filled slots in the tag memory with one tag read each (no walk
// while no slot is filled), an allocation step on a miss, then the responses.
// Flush: one tag read and one response per filled slot (one response when empty).
// A stalled rsp holds the response register and the controller waits at its
// next emit. Reset clears control state only; no clearing pass over the tags.
module sector_cache_directory #(
	parameter int SLOT_COUNT   = scd_pkg::SLOT_COUNT_DEF,
	parameter int SECTOR_BYTES = scd_pkg::SECTOR_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	scd_req_if.sink                       req,
	scd_rsp_if.source                     rsp,
	input  logic                          cfg_we,
	input  logic [scd_pkg::PERIOD_W-1:0]  cfg_wdata
);

	scd_pkg::cmd_t    cmd;
	scd_pkg::status_t st;
	logic             ready;

	// Sequence each request
	scd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.st        (st),
		.cmd       (cmd)
	);

	assign req.ready = ready;

	// Look up, allocate and build responses
	scd_dp #(
		.SLOT_COUNT   (SLOT_COUNT),
		.SECTOR_BYTES (SECTOR_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.opcode        (req.opcode),
		.sector_number (req.sector_number),
		.window_offset (req.window_offset),
		.window_length (req.window_length),
		.now_ticks     (req.now_ticks),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.cmd           (cmd),
		.st            (st),
		.rsp           (rsp)
	);

endmodule

// ----- src/scd_ctrl.sv -----
// Controller state machine of the sector cache directory.
// Depends on scd_pkg for the command and status structs.
module scd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  scd_pkg::status_t st,
	output scd_pkg::cmd_t    cmd
);

	typedef enum logic [12:0] {
		S_IDLE    = 13'h0001,
		S_DECODE  = 13'h0002,
		S_STATUS  = 13'h0004,
		S_NOTHING = 13'h0008,
		S_REJECT  = 13'h0010,
		S_SCAN    = 13'h0020,
		S_MISS    = 13'h0040,
		S_EVICT   = 13'h0080,
		S_FILL    = 13'h0100,
		S_COPY    = 13'h0200,
		S_WT      = 13'h0400,
		S_FL_RD   = 13'h0800,
		S_FL_EM   = 13'h1000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = (state_q == S_IDLE);

	// Decode next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.kind = scd_pkg::EK_NOTHING;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (st.op)
					scd_pkg::OP_DUE: begin
						state_d = S_STATUS;
					end
					scd_pkg::OP_FLUSH: begin
						cmd.set_flush_time = 1'b1;
						cmd.scan_clr       = 1'b1;
						state_d = st.fill_zero ? S_NOTHING : S_FL_RD;
					end
					scd_pkg::OP_READ, scd_pkg::OP_WRITE: begin
						if (st.reject) begin
							state_d = S_REJECT;
						end else if (st.fill_zero) begin
							state_d = S_MISS;
						end else begin
							cmd.scan_clr = 1'b1;
							state_d      = S_SCAN;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_STATUS: begin
				cmd.kind = scd_pkg::EK_STATUS;
				cmd.last = 1'b1;
				if (st.can_emit) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_NOTHING: begin
				cmd.kind = scd_pkg::EK_NOTHING;
				cmd.last = 1'b1;
				if (st.can_emit) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_REJECT: begin
				cmd.kind = scd_pkg::EK_REJECT;
				cmd.last = 1'b1;
				if (st.can_emit) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_SCAN: begin
				// Walk the filled slots, one tag compare per cycle
				cmd.scan_adv = 1'b1;
				cmd.rd_en    = 1'b1;
				if (st.s1_match) begin
					cmd.take_hit = 1'b1;
					state_d      = S_COPY;
				end else if (st.s1_last) begin
					state_d = S_MISS;
				end
			end
			S_MISS: begin
				// Take the next free slot, or fetch the victim tag
				cmd.alloc     = 1'b1;
				cmd.rd_en     = st.full;
				cmd.rd_victim = 1'b1;
				state_d = st.full ? S_EVICT : S_FILL;
			end
			S_EVICT: begin
				cmd.kind = scd_pkg::EK_EVICT;
				if (st.can_emit) begin
					cmd.emit = 1'b1;
					state_d  = S_FILL;
				end
			end
			S_FILL: begin
				cmd.kind = scd_pkg::EK_DEVREAD;
				if (st.can_emit) begin
					cmd.emit   = 1'b1;
					cmd.tag_wr = 1'b1;
					state_d    = S_COPY;
				end
			end
			S_COPY: begin
				cmd.kind = scd_pkg::EK_COPY;
				cmd.last = (st.op == scd_pkg::OP_READ);
				if (st.can_emit) begin
					cmd.emit = 1'b1;
					state_d  = (st.op == scd_pkg::OP_READ) ? S_IDLE : S_WT;
				end
			end
			S_WT: begin
				cmd.kind = scd_pkg::EK_WT;
				cmd.last = 1'b1;
				if (st.can_emit) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_FL_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_FL_EM;
			end
			S_FL_EM: begin
				cmd.kind = scd_pkg::EK_FLUSH;
				cmd.last = st.scan_last;
				if (st.can_emit) begin
					cmd.emit     = 1'b1;
					cmd.scan_adv = 1'b1;
					state_d      = st.scan_last ? S_IDLE : S_FL_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- src/scd_dp.sv -----
// Datapath of the sector cache directory: item registers, tag memory,
// fill count, victim pointer, flush timer and response register.
// Depends on scd_pkg and the response interface in scd_if.
module scd_dp #(
	parameter int SLOT_COUNT   = scd_pkg::SLOT_COUNT_DEF,
	parameter int SECTOR_BYTES = scd_pkg::SECTOR_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [scd_pkg::OPCODE_W-1:0]   opcode,
	input  logic [scd_pkg::SECTOR_W-1:0]   sector_number,
	input  logic [scd_pkg::WIN_W-1:0]      window_offset,
	input  logic [scd_pkg::WIN_W-1:0]      window_length,
	input  logic [scd_pkg::TICK_W-1:0]     now_ticks,
	input  logic                           cfg_we,
	input  logic [scd_pkg::PERIOD_W-1:0]   cfg_wdata,
	input  scd_pkg::cmd_t                  cmd,
	output scd_pkg::status_t               st,
	scd_rsp_if.source                      rsp
);

	localparam int IDX_W  = $clog2(SLOT_COUNT);
	localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
	localparam int SB_W   = $clog2(SECTOR_BYTES + 1);
	localparam int SUM_W  = (SB_W > scd_pkg::WIN_W + 1) ? SB_W : scd_pkg::WIN_W + 1;
	localparam int DUE_W  = scd_pkg::TICK_W + 1;

	// Captured item
	logic [scd_pkg::OPCODE_W-1:0] op_q;
	logic [scd_pkg::SECTOR_W-1:0] sector_q;
	logic [scd_pkg::WIN_W-1:0]    off_q;
	logic [scd_pkg::WIN_W-1:0]    len_q;
	logic [scd_pkg::TICK_W-1:0]   now_q;

	// Directory state
	logic [scd_pkg::PERIOD_W-1:0] period_q;
	logic [scd_pkg::TICK_W-1:0]   last_flush_q;
	logic [CNT_W-1:0]             fill_cnt_q;
	logic [IDX_W-1:0]             victim_q;
	logic [IDX_W-1:0]             victim_next;

	// Walk and lookup
	logic [CNT_W-1:0]             scan_q;
	logic                         valid_s1;
	logic [IDX_W-1:0]             idx_s1;
	logic [IDX_W-1:0]             slot_q;
	logic                         hit_q;
	logic [scd_pkg::SECTOR_W-1:0] rd_q;
	logic [IDX_W-1:0]             rd_addr;
	logic [scd_pkg::SECTOR_W-1:0] tag_mem [SLOT_COUNT];

	// Response register
	logic                         out_valid_q;
	scd_pkg::action_t             act_d;
	logic [scd_pkg::SECTOR_W-1:0] dsec_d;
	logic [IDX_W-1:0]             slot_d;
	logic                         hit_d;
	logic [scd_pkg::WIN_W-1:0]    off_d;
	logic [scd_pkg::WIN_W-1:0]    len_d;
	logic                         due_d;

	logic [SUM_W-1:0]             win_end;
	logic                         due_now;
	logic                         can_emit;

	assign victim_next = (victim_q == IDX_W'(SLOT_COUNT - 1)) ? '0 : victim_q + 1'b1;
	assign win_end     = SUM_W'(off_q) + SUM_W'(len_q);
	assign due_now     = {1'b0, now_q} >= ({1'b0, last_flush_q} + DUE_W'(period_q));
	assign can_emit    = !out_valid_q || rsp.ready;
	assign rd_addr     = cmd.rd_victim ? victim_next : scan_q[IDX_W-1:0];

	// Report status to the controller
	always_comb begin
		st.op        = scd_pkg::opcode_t'(op_q);
		st.reject    = win_end > SUM_W'(SECTOR_BYTES);
		st.fill_zero = (fill_cnt_q == '0);
		st.full      = (fill_cnt_q == CNT_W'(SLOT_COUNT));
		st.s1_match  = valid_s1 && (rd_q == sector_q);
		st.s1_last   = valid_s1 && ({1'b0, idx_s1} == CNT_W'(fill_cnt_q - CNT_W'(1)));
		st.scan_last = (scan_q == fill_cnt_q - CNT_W'(1));
		st.can_emit  = can_emit;
	end

	// Capture the item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= opcode;
			sector_q <= sector_number;
			off_q    <= window_offset;
			len_q    <= window_length;
			now_q    <= now_ticks;
		end
	end

	// Hold the flush period, flush time, fill count and victim pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q     <= scd_pkg::FLUSH_PERIOD_RST;
			last_flush_q <= '0;
			fill_cnt_q   <= '0;
			victim_q     <= '0;
		end else begin
			if (cfg_we) begin
				period_q <= cfg_wdata;
			end
			if (cmd.set_flush_time) begin
				last_flush_q <= now_q;
			end
			if (cmd.alloc) begin
				if (fill_cnt_q == CNT_W'(SLOT_COUNT)) begin
					victim_q <= victim_next;
				end else begin
					fill_cnt_q <= fill_cnt_q + 1'b1;
				end
			end
		end
	end

	// Advance the slot walk and pick the slot for the access
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q   <= '0;
			valid_s1 <= 1'b0;
			idx_s1   <= '0;
			slot_q   <= '0;
			hit_q    <= 1'b0;
		end else begin
			if (cmd.capture) begin
				hit_q <= 1'b0;
			end
			if (cmd.scan_clr) begin
				scan_q   <= '0;
				valid_s1 <= 1'b0;
			end else if (cmd.scan_adv) begin
				valid_s1 <= scan_q < fill_cnt_q;
				idx_s1   <= scan_q[IDX_W-1:0];
				if (scan_q != fill_cnt_q) begin
					scan_q <= scan_q + 1'b1;
				end
			end
			if (cmd.take_hit) begin
				hit_q  <= 1'b1;
				slot_q <= idx_s1;
			end else if (cmd.alloc) begin
				slot_q <= (fill_cnt_q == CNT_W'(SLOT_COUNT)) ? victim_next
					: fill_cnt_q[IDX_W-1:0];
			end
		end
	end

	// Tag memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.tag_wr) begin
			tag_mem[slot_q] <= sector_q;
		end
		if (cmd.rd_en) begin
			rd_q <= tag_mem[rd_addr];
		end
	end

	// Build the response for the requested kind
	always_comb begin
		act_d  = scd_pkg::ACT_NOTHING;
		dsec_d = '0;
		slot_d = '0;
		hit_d  = 1'b0;
		off_d  = '0;
		len_d  = '0;
		due_d  = 1'b0;
		unique case (cmd.kind)
			scd_pkg::EK_STATUS: begin
				act_d = scd_pkg::ACT_STATUS;
				due_d = due_now;
			end
			scd_pkg::EK_NOTHING: begin
				act_d = scd_pkg::ACT_NOTHING;
			end
			scd_pkg::EK_REJECT: begin
				act_d = scd_pkg::ACT_REJECTED;
			end
			scd_pkg::EK_EVICT: begin
				act_d  = scd_pkg::ACT_DEV_WRITE;
				dsec_d = rd_q;
				slot_d = slot_q;
			end
			scd_pkg::EK_DEVREAD: begin
				act_d  = scd_pkg::ACT_DEV_READ;
				dsec_d = sector_q;
				slot_d = slot_q;
			end
			scd_pkg::EK_COPY: begin
				act_d  = (op_q == scd_pkg::OP_READ) ? scd_pkg::ACT_COPY_OUT
					: scd_pkg::ACT_COPY_IN;
				slot_d = slot_q;
				hit_d  = hit_q;
				off_d  = off_q;
				len_d  = len_q;
			end
			scd_pkg::EK_WT: begin
				act_d  = scd_pkg::ACT_DEV_WRITE;
				dsec_d = sector_q;
				slot_d = slot_q;
				hit_d  = hit_q;
			end
			scd_pkg::EK_FLUSH: begin
				act_d  = scd_pkg::ACT_DEV_WRITE;
				dsec_d = rd_q;
				slot_d = scan_q[IDX_W-1:0];
			end
			default: begin
				act_d = scd_pkg::ACT_NOTHING;
			end
		endcase
	end

	// Hold the response until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp.action        <= act_d;
			rsp.device_sector <= dsec_d;
			rsp.slot_index    <= scd_pkg::SLOT_W'(slot_d);
			rsp.was_hit       <= hit_d;
			rsp.copy_offset   <= off_d;
			rsp.copy_length   <= len_d;
			rsp.flush_due     <= due_d;
			rsp.last_result   <= cmd.last;
		end
	end

	assign rsp.valid = out_valid_q;

endmodule
